### sv/lkvc_pkg.sv
// Shared constants for the LRU key/value cache: opcodes, field widths and parameter defaults.
package lkvc_pkg;

  localparam int OpcodeBits = 2;
  localparam int KeyPortBits = 32;
  localparam int ValuePortBits = 32;
  localparam int ReadDataBits = 32;

  localparam logic [OpcodeBits-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OpcodeBits-1:0] OP_INSERT = 2'd1;
  localparam logic [OpcodeBits-1:0] OP_DELETE = 2'd2;

  localparam int DefaultEntries = 16;
  localparam int DefaultKeyBits = 32;
  localparam int DefaultDataBits = 32;

endpackage

### sv/lru_key_value_cache.sv
// Fully associative LRU key/value cache with a sequencer that walks the entries.
// A hit, insert or successful delete passes through the scan, the decision, the rank update
// pass and the result register; a miss, a failed delete or an unused opcode skips the update
// pass, and any result may wait for the previous result to be taken.
// Throughput: one transaction at a time, set by the single key compare and rank update units
// that each visit one entry per cycle; the next is taken the cycle after the result loads.
// Reset (rst, synchronous, active high) clears all valid bits, ranks and the entry count
// at once; keys and values are not cleared and are only read for valid entries.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DefaultEntries,
  parameter int KEY_BITS = lkvc_pkg::DefaultKeyBits,
  parameter int DATA_BITS = lkvc_pkg::DefaultDataBits
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] read_data
  output logic        m_tuser    // [0] success
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // entry index and rank width
  localparam int CW = $clog2(ENTRIES + 1);                  // entry count width
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FullCount = CW'(ENTRIES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;

  // Latched request.
  logic [lkvc_pkg::OpcodeBits-1:0] op;
  logic [KEY_BITS-1:0]  req_key;
  logic [DATA_BITS-1:0] req_val;

  // Entry storage. Keys and values live in memories with a registered read port; the
  // valid bits and ranks are flip-flops so that reset can clear them at once.
  logic [KEY_BITS-1:0]  keys [ENTRIES];
  logic [DATA_BITS-1:0] vals [ENTRIES];
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] val_q;
  logic [ENTRIES-1:0]   valid;
  logic [IW-1:0]        rank [ENTRIES];
  logic [CW-1:0]        count;

  // Walk counter shared by the scan and the rank update pass.
  logic [IW-1:0] cnt;
  logic          issue_done;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;

  // What the scan found.
  logic                 hit_found;
  logic [IW-1:0]        hit_idx;
  logic [DATA_BITS-1:0] hit_val;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic                 lru_found;
  logic [IW-1:0]        lru_idx;

  // Plan for the update pass and the result.
  logic          dec_mode;  // 1: ranks above the threshold move down; 0: ranks below move up
  logic [IW-1:0] tgt;
  logic [IW-1:0] thr;
  logic          res_ok;
  logic [31:0]   res_data;

  // Decision, worked out in the cycle after the scan.
  logic                 d_update;
  logic [IW-1:0]        d_tgt;
  logic [IW-1:0]        d_thr;
  logic                 d_dec;
  logic                 d_ok;
  logic [31:0]          d_data;
  logic                 d_we_key;
  logic                 d_we_val;
  logic                 d_set_valid;
  logic                 d_clr_valid;
  logic                 d_cnt_inc;
  logic                 d_cnt_dec;
  logic [CW-1:0]        count_m1;
  logic                 cmp_match;
  logic                 upd_adjust;

  assign s_tready = (state == ST_IDLE);
  assign count_m1 = count - CW'(1);

  // The shared key compare unit: one stored key against the request key per cycle.
  assign cmp_match = valid[rd_idx] && (key_q == req_key);

  // The shared rank compare unit used during the update pass.
  assign upd_adjust = valid[cnt] && (cnt != tgt) &&
                      (dec_mode ? (rank[cnt] > thr) : (rank[cnt] < thr));

  always_comb begin
    d_update    = 1'b0;
    d_tgt       = hit_idx;
    d_thr       = rank[hit_idx];
    d_dec       = 1'b0;
    d_ok        = 1'b0;
    d_data      = '0;
    d_we_key    = 1'b0;
    d_we_val    = 1'b0;
    d_set_valid = 1'b0;
    d_clr_valid = 1'b0;
    d_cnt_inc   = 1'b0;
    d_cnt_dec   = 1'b0;
    unique case (op)
      lkvc_pkg::OP_LOOKUP: begin
        if (hit_found) begin
          d_update = 1'b1;
          d_ok     = 1'b1;
          d_data   = 32'(hit_val);
        end
      end
      lkvc_pkg::OP_INSERT: begin
        d_update = 1'b1;
        d_ok     = 1'b1;
        d_we_val = 1'b1;
        if (!hit_found) begin
          d_we_key = 1'b1;
          if (count < FullCount) begin
            // A new entry enters below every present one, then moves to the front.
            d_tgt       = free_idx;
            d_thr       = IW'(count);
            d_set_valid = 1'b1;
            d_cnt_inc   = 1'b1;
          end else begin
            // Full: the least recent entry is overwritten.
            d_tgt = lru_found ? lru_idx : '0;
            d_thr = lru_found ? rank[lru_idx] : rank[0];
          end
        end
      end
      lkvc_pkg::OP_DELETE: begin
        if (hit_found && (count != '0)) begin
          d_update    = 1'b1;
          d_ok        = 1'b1;
          d_dec       = 1'b1;
          d_clr_valid = 1'b1;
          d_cnt_dec   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Key and value memories.
  always_ff @(posedge clk) begin
    if ((state == ST_DECIDE) && d_we_key) begin
      keys[d_tgt] <= req_key;
    end
    if ((state == ST_DECIDE) && d_we_val) begin
      vals[d_tgt] <= req_val;
    end
    key_q <= keys[cnt];
    val_q <= vals[cnt];
  end

  // Request, scan results and plan (payload, no reset needed).
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op      <= s_tuser;
      req_key <= KEY_BITS'(s_tdata[lkvc_pkg::KeyPortBits-1:0]);
      req_val <= DATA_BITS'(s_tdata[lkvc_pkg::KeyPortBits +: lkvc_pkg::ValuePortBits]);
    end
    if ((state == ST_SCAN) && rd_vld) begin
      if (cmp_match && !hit_found) begin
        hit_idx <= rd_idx;
        hit_val <= val_q;
      end
      if (!valid[rd_idx] && !free_found) begin
        free_idx <= rd_idx;
      end
      if (valid[rd_idx] && (CW'(rank[rd_idx]) == count_m1) && !lru_found) begin
        lru_idx <= rd_idx;
      end
    end
    if (state == ST_DECIDE) begin
      tgt      <= d_tgt;
      thr      <= d_thr;
      dec_mode <= d_dec;
      res_ok   <= d_ok;
      res_data <= d_data;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      rd_idx     <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      lru_found  <= 1'b0;
      valid      <= '0;
      count      <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      m_tuser    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state      <= ST_SCAN;
            cnt        <= '0;
            issue_done <= 1'b0;
            rd_vld     <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            lru_found  <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Read at cnt this cycle, compare that entry the next.
          if (!issue_done) begin
            rd_vld <= 1'b1;
            rd_idx <= cnt;
            cnt    <= cnt + IW'(1);
            if (cnt == LastIdx) begin
              issue_done <= 1'b1;
            end
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (cmp_match) begin
              hit_found <= 1'b1;
            end
            if (!valid[rd_idx]) begin
              free_found <= 1'b1;
            end
            if (valid[rd_idx] && (CW'(rank[rd_idx]) == count_m1)) begin
              lru_found <= 1'b1;
            end
            if (rd_idx == LastIdx) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          if (d_set_valid) begin
            valid[d_tgt] <= 1'b1;
          end
          if (d_clr_valid) begin
            valid[d_tgt] <= 1'b0;
          end
          if (d_cnt_inc) begin
            count <= count + CW'(1);
          end
          if (d_cnt_dec) begin
            count <= count_m1;
          end
          state <= d_update ? ST_UPDATE : ST_EMIT;
        end
        ST_UPDATE: begin
          // One rank per cycle: the target goes to rank zero, the others past the threshold shift by one.
          if (cnt == tgt) begin
            rank[cnt] <= '0;
          end else if (upd_adjust) begin
            rank[cnt] <= dec_mode ? (rank[cnt] - IW'(1)) : (rank[cnt] + IW'(1));
          end
          cnt <= cnt + IW'(1);
          if (cnt == LastIdx) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_data;
            m_tuser  <= res_ok;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The entry count always matches the number of valid entries between transactions.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == int'(count)))
    else $error("entry count does not match the valid bits");

  // A transaction that is taken closes the request side until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request side stayed open after a transaction was accepted");

  // A failed request never carries data.
  a_fail_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed result carries nonzero data");

  // The count never exceeds the number of entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (count <= FullCount))
    else $error("entry count exceeds the cache size");

endmodule
